FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the flash command decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active-low reset).
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cfd_pkg.sv
// Types, command codes and ID/CFI ROM contents for the flash command decoder.
`default_nettype none

package cfd_pkg;

    localparam int ADDRESS_BITS      = 23;
    localparam int DATA_BITS         = 16;
    localparam int SECURE_WORDS      = 128;
    localparam int SECURE_INDEX_BITS = $clog2(SECURE_WORDS);
    localparam int CFI_TABLE_WORDS   = 45;
    localparam int CFI_INDEX_BITS    = $clog2(CFI_TABLE_WORDS);
    localparam int CFI_BASE          = 16;
    localparam int CFI_END           = CFI_BASE + CFI_TABLE_WORDS;
    localparam int BANK_LSB          = 15;
    localparam int BANK_BITS         = 8;
    localparam int CMD_ADDR_BITS     = 12;
    localparam int CMD_DATA_BITS     = 8;

    // Bus access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Command modes
    localparam logic [3:0] M_READ        = 4'd0;
    localparam logic [3:0] M_UNLOCKED    = 4'd1;
    localparam logic [3:0] M_AUTOSEL     = 4'd2;
    localparam logic [3:0] M_PROGRAM     = 4'd3;
    localparam logic [3:0] M_ERASE_INIT  = 4'd4;
    localparam logic [3:0] M_ERASE_UNL   = 4'd5;
    localparam logic [3:0] M_CFI         = 4'd6;
    localparam logic [3:0] M_SECURE      = 4'd7;
    localparam logic [3:0] M_SECURE_EXIT = 4'd8;

    // Read sources
    localparam logic [2:0] SRC_NONE   = 3'd0;
    localparam logic [2:0] SRC_ARRAY  = 3'd1;
    localparam logic [2:0] SRC_SECURE = 3'd2;
    localparam logic [2:0] SRC_ID     = 3'd3;
    localparam logic [2:0] SRC_CFI    = 3'd4;

    // Array operations
    localparam logic [1:0] OP_NONE         = 2'd0;
    localparam logic [1:0] OP_PROGRAM      = 2'd1;
    localparam logic [1:0] OP_SECTOR_ERASE = 2'd2;
    localparam logic [1:0] OP_CHIP_ERASE   = 2'd3;

    // Command cycle addresses (low 12 bits)
    localparam logic [CMD_ADDR_BITS-1:0] ADDR_UNLOCK1 = 12'h555;
    localparam logic [CMD_ADDR_BITS-1:0] ADDR_UNLOCK2 = 12'h2AA;
    localparam logic [CMD_ADDR_BITS-1:0] ADDR_CFI     = 12'h055;

    // Command cycle data (low 8 bits)
    localparam logic [CMD_DATA_BITS-1:0] CMD_UNLOCK1      = 8'hAA;
    localparam logic [CMD_DATA_BITS-1:0] CMD_UNLOCK2      = 8'h55;
    localparam logic [CMD_DATA_BITS-1:0] CMD_RESET        = 8'hF0;
    localparam logic [CMD_DATA_BITS-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [CMD_DATA_BITS-1:0] CMD_SECURE_ENTER = 8'h88;
    localparam logic [CMD_DATA_BITS-1:0] CMD_AUTOSELECT   = 8'h90;
    localparam logic [CMD_DATA_BITS-1:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [CMD_DATA_BITS-1:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [CMD_DATA_BITS-1:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [CMD_DATA_BITS-1:0] CMD_CFI_QUERY    = 8'h98;
    localparam logic [CMD_DATA_BITS-1:0] CMD_SECURE_EXIT  = 8'h00;

    // Autoselect address masks per device
    localparam logic [3:0] ID_MASK [2] = '{4'h3, 4'hF};

    localparam logic [DATA_BITS-1:0] ID_ROM [2][16] = '{
        '{16'h0020, 16'h2257, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0001, 16'h227E, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h2210, 16'h2200}
    };

    localparam logic [7:0] CFI_ROM [2][CFI_TABLE_WORDS] = '{
        '{8'h51, 8'h52, 8'h59, 8'h02, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h27, 8'h36, 8'hB5, 8'hC5, 8'h04, 8'h00, 8'h0A, 8'h00, 8'h04, 8'h00, 8'h03,
          8'h00, 8'h16, 8'h02, 8'h00, 8'h00, 8'h00, 8'h02, 8'h07, 8'h00, 8'h20, 8'h00,
          8'h3E, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00},
        '{8'h51, 8'h52, 8'h59, 8'h02, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h27, 8'h36, 8'h00, 8'h00, 8'h07, 8'h07, 8'h0A, 8'h00, 8'h03, 8'h05, 8'h04,
          8'h00, 8'h17, 8'h02, 8'h00, 8'h05, 8'h00, 8'h02, 8'h07, 8'h00, 8'h20, 8'h00,
          8'h7E, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00}
    };

    typedef struct packed {
        logic                    func;
        logic [ADDRESS_BITS-1:0] word_address;
        logic [DATA_BITS-1:0]    write_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_BITS-1:0]         read_data;
        logic [2:0]                   read_source;
        logic [SECURE_INDEX_BITS-1:0] secure_index;
        logic [1:0]                   array_op;
        logic [BANK_BITS-1:0]         op_bank;
        logic [ADDRESS_BITS-1:0]      op_word_address;
        logic [DATA_BITS-1:0]         op_data;
        logic [3:0]                   mode_now;
    } t_out_item;

    // Handshake between the decode core and the output register
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

`default_nettype wire

FILE: rtl/cfd_in_stage.sv
// Input register of the flash command decoder.
`default_nettype none

module cfd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire cfd_pkg::t_in_item i_item,
    input  wire logic              i_take,
    output logic                   o_valid,
    output cfd_pkg::t_in_item      o_item
);

    logic              r_valid;
    logic              n_valid;
    cfd_pkg::t_in_item r_item;
    logic              accept;

    // Slot is free when empty or being drained this cycle.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: rtl/cfd_core.sv
// Command state machine and read decode of the flash command decoder.
`default_nettype none

module cfd_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    input  wire cfd_pkg::t_hs      i_hs,
    input  wire cfd_pkg::t_in_item i_item,
    output cfd_pkg::t_out_item     o_result
);

    logic                                    r_device_type;
    logic [3:0]                              r_mode;
    logic [3:0]                              n_mode;
    logic [cfd_pkg::ADDRESS_BITS-1:0]        r_last_addr;
    logic [cfd_pkg::ADDRESS_BITS-1:0]        n_last_addr;
    logic [cfd_pkg::DATA_BITS-1:0]           r_last_data;
    logic [cfd_pkg::DATA_BITS-1:0]           n_last_data;
    logic                                    fire;
    logic [cfd_pkg::CMD_ADDR_BITS-1:0]       cmd_a;
    logic [cfd_pkg::CMD_DATA_BITS-1:0]       cmd_d;
    logic [cfd_pkg::BANK_BITS-1:0]           bank;
    logic                                    unlock_seen;
    logic                                    prev_is_555;
    logic                                    cfi_hit;
    logic [cfd_pkg::CFI_INDEX_BITS-1:0]      cfi_idx;
    logic [3:0]                              id_idx;
    cfd_pkg::t_out_item                      res;

    assign fire  = i_hs.valid && i_hs.ready;
    assign cmd_a = i_item.word_address[cfd_pkg::CMD_ADDR_BITS-1:0];
    assign cmd_d = i_item.write_data[cfd_pkg::CMD_DATA_BITS-1:0];
    assign bank  = i_item.word_address[cfd_pkg::BANK_LSB +: cfd_pkg::BANK_BITS];

    assign prev_is_555 =
        r_last_addr == cfd_pkg::ADDRESS_BITS'(cfd_pkg::ADDR_UNLOCK1);
    assign unlock_seen = prev_is_555
        && r_last_data == cfd_pkg::DATA_BITS'(cfd_pkg::CMD_UNLOCK1)
        && cmd_a == cfd_pkg::ADDR_UNLOCK2
        && cmd_d == cfd_pkg::CMD_UNLOCK2;

    // CFI window is word addresses 0x10..0x3C
    assign cfi_hit =
        i_item.word_address >= cfd_pkg::ADDRESS_BITS'(cfd_pkg::CFI_BASE)
        && i_item.word_address < cfd_pkg::ADDRESS_BITS'(cfd_pkg::CFI_END);
    assign cfi_idx = i_item.word_address[cfd_pkg::CFI_INDEX_BITS-1:0]
        - cfd_pkg::CFI_INDEX_BITS'(cfd_pkg::CFI_BASE);
    assign id_idx  = i_item.word_address[3:0] & cfd_pkg::ID_MASK[r_device_type];

    always_comb begin
        res         = '0;
        n_mode      = r_mode;
        n_last_addr = r_last_addr;
        n_last_data = r_last_data;

        if (i_item.func == cfd_pkg::FUNC_READ) begin
            if (r_mode >= cfd_pkg::M_SECURE) begin
                res.read_source  = cfd_pkg::SRC_SECURE;
                res.secure_index =
                    i_item.word_address[cfd_pkg::SECURE_INDEX_BITS-1:0];
            end else if (r_mode == cfd_pkg::M_AUTOSEL) begin
                res.read_source = cfd_pkg::SRC_ID;
                res.read_data   = cfd_pkg::ID_ROM[r_device_type][id_idx];
            end else if (r_mode == cfd_pkg::M_CFI && cfi_hit) begin
                res.read_source = cfd_pkg::SRC_CFI;
                res.read_data   = {8'h00, cfd_pkg::CFI_ROM[r_device_type][cfi_idx]};
            end else begin
                res.read_source = cfd_pkg::SRC_ARRAY;
            end
        end else if (r_mode == cfd_pkg::M_PROGRAM) begin
            // Data cycle of a program: unmasked address and data
            if (bank != '0) begin
                res.array_op        = cfd_pkg::OP_PROGRAM;
                res.op_bank         = bank;
                res.op_word_address = i_item.word_address;
                res.op_data         = i_item.write_data;
            end
            n_mode      = cfd_pkg::M_READ;
            n_last_addr = i_item.word_address;
            n_last_data = i_item.write_data;
        end else begin
            if (cmd_d == cfd_pkg::CMD_RESET && r_mode < cfd_pkg::M_SECURE) begin
                n_mode = cfd_pkg::M_READ;
            end else begin
                case (r_mode)
                    cfd_pkg::M_UNLOCKED: begin
                        if (cmd_a == cfd_pkg::ADDR_UNLOCK1) begin
                            if (cmd_d == cfd_pkg::CMD_ERASE_SETUP) begin
                                n_mode = cfd_pkg::M_ERASE_INIT;
                            end else if (cmd_d == cfd_pkg::CMD_SECURE_ENTER) begin
                                n_mode = cfd_pkg::M_SECURE;
                            end else if (cmd_d == cfd_pkg::CMD_AUTOSELECT) begin
                                n_mode = cfd_pkg::M_AUTOSEL;
                            end else if (cmd_d == cfd_pkg::CMD_PROGRAM) begin
                                n_mode = cfd_pkg::M_PROGRAM;
                            end
                        end
                    end
                    cfd_pkg::M_SECURE: begin
                        if (unlock_seen) begin
                            n_mode = cfd_pkg::M_SECURE_EXIT;
                        end
                    end
                    cfd_pkg::M_SECURE_EXIT: begin
                        if (prev_is_555
                            && r_last_data == cfd_pkg::DATA_BITS'(cfd_pkg::CMD_AUTOSELECT)
                            && cmd_d == cfd_pkg::CMD_SECURE_EXIT) begin
                            n_mode = cfd_pkg::M_READ;
                        end
                    end
                    cfd_pkg::M_ERASE_INIT: begin
                        if (unlock_seen) begin
                            n_mode = cfd_pkg::M_ERASE_UNL;
                        end
                    end
                    cfd_pkg::M_ERASE_UNL: begin
                        if (cmd_a == cfd_pkg::ADDR_UNLOCK1
                            && cmd_d == cfd_pkg::CMD_CHIP_ERASE) begin
                            res.array_op = cfd_pkg::OP_CHIP_ERASE;
                            n_mode       = cfd_pkg::M_READ;
                        end else if (cmd_d == cfd_pkg::CMD_SECTOR_ERASE) begin
                            if (bank != '0) begin
                                res.array_op = cfd_pkg::OP_SECTOR_ERASE;
                                res.op_bank  = bank;
                            end
                            n_mode = cfd_pkg::M_READ;
                        end
                    end
                    default: begin
                        // read, autoselect and CFI modes
                        if (unlock_seen) begin
                            n_mode = cfd_pkg::M_UNLOCKED;
                        end else if (cmd_a == cfd_pkg::ADDR_CFI
                                     && cmd_d == cfd_pkg::CMD_CFI_QUERY) begin
                            n_mode = cfd_pkg::M_CFI;
                        end
                    end
                endcase
            end
            n_last_addr = cfd_pkg::ADDRESS_BITS'(cmd_a);
            n_last_data = cfd_pkg::DATA_BITS'(cmd_d);
        end

        res.mode_now = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_type <= 1'b0;
            r_mode        <= cfd_pkg::M_READ;
            r_last_addr   <= '0;
            r_last_data   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_device_type <= i_cfg_data;
            end
            if (fire) begin
                r_mode      <= n_mode;
                r_last_addr <= n_last_addr;
                r_last_data <= n_last_data;
            end
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

FILE: rtl/cfd_out_stage.sv
// Result register of the flash command decoder.
`default_nettype none

module cfd_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cfd_pkg::t_out_item i_result,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output cfd_pkg::t_out_item      o_result
);

    logic               r_valid;
    logic               n_valid;
    cfd_pkg::t_out_item r_result;
    logic               load;

    assign o_ready = !r_valid || !i_stall;
    assign load    = i_valid && o_ready;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/cfi_flash_command_decoder.sv
// Top level of the NOR flash command decoder (unlock/command state machine, ID and CFI reads).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one bus access per
//   transaction: func (0 read, 1 write), word address and write data.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one result
//   transaction per input: read source and ID/CFI data, secured-area index, the
//   program/erase command for the external array, and the command mode afterwards.
//   Config: i_cfg_we writes i_cfg_data into device_type (ID/CFI tables, ID mask).
//   Write it only while no transaction is in flight.
// Timing:
//   Two register stages: input register, then decode into the result register.
//   Each transaction is registered in the input register, then decoded into the result
//   register; result valid rises once the result is loaded there.
//   Throughput is one transaction per cycle while the output is not stalled; the command
//   state updates as an item moves from the input register into the result register.
// Reset (synchronous, active low): mode returns to array read, address/data latches
//   and device_type clear, both stages empty.
// Stall: a stalled result holds; the input register keeps taking one more
//   transaction, after which o_in_stall rises until the result drains.
`default_nettype none

module cfi_flash_command_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire cfd_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output cfd_pkg::t_out_item      o_out_data
);

    logic               in_q_valid;
    cfd_pkg::t_in_item  in_q_item;
    logic               out_ready;
    cfd_pkg::t_hs       core_hs;
    cfd_pkg::t_out_item core_result;

    cfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_data),
        .i_take  (core_hs.valid && core_hs.ready),
        .o_valid (in_q_valid),
        .o_item  (in_q_item)
    );

    // The decode step fires when the input register holds an item and the
    // result register can take it.
    assign core_hs.valid = in_q_valid;
    assign core_hs.ready = out_ready;

    cfd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_hs       (core_hs),
        .i_item     (in_q_item),
        .o_result   (core_result)
    );

    cfd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_q_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/cfd_checker.sv
// Port-level checker for the flash command decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module cfd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_stall,
    input wire cfd_pkg::t_out_item i_out_data
);

    `CFD_ASSERT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid, "result valid dropped while stalled")
    `CFD_ASSERT(a_out_data_holds, i_clk, i_rst_n, i_out_valid && i_out_stall |=> $stable(i_out_data), "result changed while stalled")
    `CFD_ASSERT(a_op_only_on_write, i_clk, i_rst_n, i_out_valid && i_out_data.array_op != cfd_pkg::OP_NONE |-> i_out_data.read_source == cfd_pkg::SRC_NONE && i_out_data.mode_now == cfd_pkg::M_READ, "array op without a write that ends in read mode")
    `CFD_ASSERT(a_program_bank, i_clk, i_rst_n, i_out_valid && i_out_data.array_op == cfd_pkg::OP_PROGRAM |-> i_out_data.op_bank != '0 && i_out_data.op_bank == i_out_data.op_word_address[22:15], "program to protected or mismatched bank")
    `CFD_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")

endmodule

bind cfi_flash_command_decoder cfd_checker u_cfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
